[rtl/core/pwsfd_pkg.sv]
// Shared types, constants and helpers for the pulse width sensor frame decoder.
// No dependencies; imported by the decoder core.
package pwsfd_pkg;

    localparam int unsigned TIMER_BITS_DEF = 16;
    localparam int unsigned IV_IN_W        = 16;  // width of the interval field
    localparam int unsigned CFG_W          = 16;
    localparam int unsigned CFG_IDX_W      = 3;
    localparam int unsigned IDX_W          = 7;
    localparam int unsigned FRAME_W        = 40;
    localparam int unsigned NUM_INTERVALS  = 82;
    localparam int unsigned RESP_INTERVALS = 2;

    // Register reset values
    localparam logic [CFG_W-1:0] RESPONSE_MIN_RST = 16'd60;
    localparam logic [CFG_W-1:0] RESPONSE_MAX_RST = 16'd100;
    localparam logic [CFG_W-1:0] LOW_MIN_RST      = 16'd35;
    localparam logic [CFG_W-1:0] LOW_MAX_RST      = 16'd70;
    localparam logic [CFG_W-1:0] ZERO_MIN_RST     = 16'd10;
    localparam logic [CFG_W-1:0] ZERO_MAX_RST     = 16'd45;
    localparam logic [CFG_W-1:0] ONE_MIN_RST      = 16'd55;
    localparam logic [CFG_W-1:0] ONE_MAX_RST      = 16'd95;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RESPONSE_MIN = 3'd0,
        REG_RESPONSE_MAX = 3'd1,
        REG_LOW_MIN      = 3'd2,
        REG_LOW_MAX      = 3'd3,
        REG_ZERO_MIN     = 3'd4,
        REG_ZERO_MAX     = 3'd5,
        REG_ONE_MIN      = 3'd6,
        REG_ONE_MAX      = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_START    = 2'd0,
        MODE_INTERVAL = 2'd1,
        MODE_TIMEOUT  = 2'd2,
        MODE_NONE     = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_BAD_RESP  = 3'd1,
        STAT_BAD_LOW   = 3'd2,
        STAT_BAD_HIGH  = 3'd3,
        STAT_SHORT     = 3'd4,
        STAT_CHECKSUM  = 3'd5
    } status_t;

    function automatic logic in_window(input logic [CFG_W-1:0] v,
                                       input logic [CFG_W-1:0] lo,
                                       input logic [CFG_W-1:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

endpackage

[rtl/core/pulse_width_sensor_frame_decoder_core.sv]
// Pulse width sensor frame decoder: the whole block in one module.
// Depends on pwsfd_pkg for types, reset values and the window compare.
//
// Usage:
//   s_ channel: one item per line edge. s_tuser carries the mode (start a new
//   frame, edge interval, idle timeout); s_tdata carries the interval in
//   microseconds. Only the timeout item produces a result item on the m_
//   channel: m_tuser holds the status, m_tdata the humidity and temperature
//   in tenths (zero unless the status is ok).
//   cfg_ channel: register writes, always ready; write only while idle.
// Path: an item is registered on accept in the input register and then processed;
//   a timeout result is registered in the result register, which drives m_tvalid.
// Throughput: one item per cycle unless a stalled timeout holds the stage. The single
//   processing stage is the limit; range checks, the bit shift and the checksum add all fit in it.
// Reset: aresetn (synchronous, active low) clears the frame state, empties
//   both registers and restores the window registers to their defaults.
// Stall: while m_tready is low and a result is held, start and interval items
//   keep flowing through the stage; a timeout item reaching the stage holds
//   there and blocks s_tready until the held result is taken.
module pulse_width_sensor_frame_decoder_core #(
    parameter int unsigned TIMER_BITS = pwsfd_pkg::TIMER_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input items
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [15:0]                           s_tdata,   // [15:0] interval
    input  logic [1:0]                            s_tuser,   // [1:0] mode
    // result items
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [31:0]                           m_tdata,   // [15:0] humidity_tenths,
                                                             // [31:16] temperature_tenths
    output logic [2:0]                            m_tuser,   // [2:0] status
    // configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pwsfd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pwsfd_pkg::CFG_W-1:0]           cfg_data
);
    import pwsfd_pkg::*;

    // Kept interval bits: the timer never counts past TIMER_BITS.
    localparam int unsigned IV_W = (TIMER_BITS < IV_IN_W) ? TIMER_BITS : IV_IN_W;

    // Window registers
    logic [CFG_W-1:0] resp_min_reg, resp_max_reg, low_min_reg, low_max_reg;
    logic [CFG_W-1:0] zero_min_reg, zero_max_reg, one_min_reg, one_max_reg;

    // Input register
    logic            s1_vld_reg;
    mode_t           s1_mode_reg;
    logic [IV_W-1:0] s1_iv_reg;

    // Frame state
    logic [IDX_W-1:0]   idx_reg, idx_next;
    status_t            err_reg, err_next;
    logic [FRAME_W-1:0] bits_reg, bits_next;

    // Result register
    logic        m_vld_reg, m_vld_next;
    status_t     m_stat_reg, m_stat_next;
    logic [15:0] m_hum_reg, m_hum_next;
    logic [15:0] m_tmp_reg, m_tmp_next;

    logic            s1_go;
    logic            proc;
    logic            s_acc;
    logic [CFG_W-1:0] iv;
    logic            is_zero, is_one;
    logic [7:0]      b0, b1, b2, b3, b4, csum;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            resp_min_reg <= RESPONSE_MIN_RST;
            resp_max_reg <= RESPONSE_MAX_RST;
            low_min_reg  <= LOW_MIN_RST;
            low_max_reg  <= LOW_MAX_RST;
            zero_min_reg <= ZERO_MIN_RST;
            zero_max_reg <= ZERO_MAX_RST;
            one_min_reg  <= ONE_MIN_RST;
            one_max_reg  <= ONE_MAX_RST;
        end else if (cfg_valid) begin
            unique case (reg_idx_t'(cfg_index))
                REG_RESPONSE_MIN: resp_min_reg <= cfg_data;
                REG_RESPONSE_MAX: resp_max_reg <= cfg_data;
                REG_LOW_MIN:      low_min_reg  <= cfg_data;
                REG_LOW_MAX:      low_max_reg  <= cfg_data;
                REG_ZERO_MIN:     zero_min_reg <= cfg_data;
                REG_ZERO_MAX:     zero_max_reg <= cfg_data;
                REG_ONE_MIN:      one_min_reg  <= cfg_data;
                REG_ONE_MAX:      one_max_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    // A timeout item needs the result register free (or being drained).
    assign s1_go    = !(s1_mode_reg == MODE_TIMEOUT && m_vld_reg && !m_tready);
    assign proc     = s1_vld_reg && s1_go;
    assign s_tready = !s1_vld_reg || s1_go;
    assign s_acc    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (s_tready) begin
            s1_vld_reg <= s_tvalid;
        end
    end

    // Payload: capture only the timer bits of the interval.
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_mode_reg <= mode_t'(s_tuser);
            s1_iv_reg   <= s_tdata[IV_W-1:0];
        end
    end

    // ---------------- processing stage ----------------
    assign iv      = CFG_W'(s1_iv_reg);
    assign is_zero = in_window(iv, zero_min_reg, zero_max_reg);
    assign is_one  = in_window(iv, one_min_reg, one_max_reg);

    assign b0   = bits_reg[39:32];
    assign b1   = bits_reg[31:24];
    assign b2   = bits_reg[23:16];
    assign b3   = bits_reg[15:8];
    assign b4   = bits_reg[7:0];
    assign csum = 8'(b0 + b1 + b2 + b3);

    always_comb begin
        idx_next    = idx_reg;
        err_next    = err_reg;
        bits_next   = bits_reg;
        m_vld_next  = m_vld_reg && !m_tready;
        m_stat_next = m_stat_reg;
        m_hum_next  = m_hum_reg;
        m_tmp_next  = m_tmp_reg;

        if (proc) begin
            unique case (s1_mode_reg)
                MODE_START: begin
                    idx_next  = '0;
                    err_next  = STAT_OK;
                    bits_next = '0;
                end
                MODE_INTERVAL: begin
                    // Drop intervals past the end of the frame.
                    if (idx_reg < IDX_W'(NUM_INTERVALS)) begin
                        if (idx_reg < IDX_W'(RESP_INTERVALS)) begin
                            if (!in_window(iv, resp_min_reg, resp_max_reg) &&
                                err_reg == STAT_OK) begin
                                err_next = STAT_BAD_RESP;
                            end
                        end else if (!idx_reg[0]) begin
                            if (!in_window(iv, low_min_reg, low_max_reg) &&
                                err_reg == STAT_OK) begin
                                err_next = STAT_BAD_LOW;
                            end
                        end else begin
                            // Zero window wins over the one window; an interval in neither is bad.
                            bits_next = {bits_reg[FRAME_W-2:0], !is_zero && is_one};
                            if (!is_zero && !is_one && err_reg == STAT_OK) begin
                                err_next = STAT_BAD_HIGH;
                            end
                        end
                        idx_next = idx_reg + 1'b1;
                    end
                end
                MODE_TIMEOUT: begin
                    m_vld_next = 1'b1;
                    m_hum_next = '0;
                    m_tmp_next = '0;
                    priority if (err_reg != STAT_OK) begin
                        m_stat_next = err_reg;
                    end else if (idx_reg < IDX_W'(NUM_INTERVALS)) begin
                        m_stat_next = STAT_SHORT;
                    end else if (csum != b4) begin
                        m_stat_next = STAT_CHECKSUM;
                    end else begin
                        m_stat_next = STAT_OK;
                        m_hum_next  = {b0, b1};
                        m_tmp_next  = {b2, b3};
                    end
                end
                default: ;  // unused mode: no effect
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            err_reg   <= STAT_OK;
            bits_reg  <= '0;
            m_vld_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            err_reg   <= err_next;
            bits_reg  <= bits_next;
            m_vld_reg <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_stat_reg <= m_stat_next;
        m_hum_reg  <= m_hum_next;
        m_tmp_reg  <= m_tmp_next;
    end

    assign m_tvalid = m_vld_reg;
    assign m_tuser  = m_stat_reg;
    assign m_tdata  = {m_tmp_reg, m_hum_reg};

    // ---------------- assertions ----------------
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= IDX_W'(NUM_INTERVALS))
        else $error("interval count ran past the frame length");

    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != STAT_OK && !(proc && s1_mode_reg == MODE_START))
        |=> err_reg == $past(err_reg))
        else $error("first error was overwritten inside a frame");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_vld_reg && m_stat_reg != STAT_OK) |-> (m_hum_reg == '0 && m_tmp_reg == '0))
        else $error("failed frame carries nonzero readings");

    a_timeout_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_vld_reg && !s1_go) |=> (s1_vld_reg && s1_mode_reg == MODE_TIMEOUT))
        else $error("stalled timeout item left the stage");

endmodule
